// ===== rtl/core/sliding_window_top_x_frequency_sum_unit_defines.svh =====
// assertion macros for the sliding window top-x frequency sum unit
`ifndef SLIDING_WINDOW_TOP_X_FREQUENCY_SUM_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_TOP_X_FREQUENCY_SUM_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SWTX_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("swtx assertion failed");
`define SWTX_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("swtx assertion failed");
`else
`define SWTX_ASSERT(lbl, clk, rstn, prop)
`define SWTX_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/core/swtx_pkg.sv =====
// shared constants and types for the sliding window top-x frequency sum unit
package swtx_pkg;
    localparam int WINDOW_MAX_DEF = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int REG_W          = 11;
    localparam int SUM_W          = 42;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT  = 2'd1;

    typedef struct packed {
        logic clear;
        logic mul;
        logic acc;
    } mac_ctl_t;
endpackage

// ===== rtl/core/swtx_ram.sv =====
// simple dual port synchronous memory, one write and one registered read
module swtx_ram import swtx_pkg::*; #(
    parameter int DEPTH = WINDOW_MAX_DEF,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/swtx_mac.sv =====
// count times value multiplier with 42-bit wrapping accumulator
module swtx_mac import swtx_pkg::*; #(
    parameter int CW = 11,
    parameter int VB = VALUE_BITS_DEF
) (
    input  logic                    clk,
    input  mac_ctl_t                ctl,
    input  logic [CW-1:0]           cnt,
    input  logic [VB-1:0]           val,
    output logic signed [SUM_W-1:0] acc
);
    localparam int PW = CW + 1 + VB;

    logic signed [PW-1:0]    prod_w;
    logic signed [SUM_W-1:0] prod_ext;
    logic signed [SUM_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] acc_reg;

    assign prod_w = $signed({1'b0, cnt}) * $signed(val);

    generate
        if (PW >= SUM_W)
        begin : g_trunc
            assign prod_ext = prod_w[SUM_W-1:0];
        end
        else
        begin : g_ext
            assign prod_ext = {{(SUM_W-PW){prod_w[PW-1]}}, prod_w};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= prod_ext;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc = acc_reg;
endmodule

// ===== rtl/core/sliding_window_top_x_frequency_sum_unit.sv =====
// top level of the sliding window top-x frequency sum unit
// usage:
// - input channel in_valid / in_stall carries value and last; a transaction
//   happens when in_valid is high and in_stall low at a rising edge
// - output channel out_valid / out_stall carries window_sum and partial
// - cfg_we writes cfg_data to register cfg_index (0 window_len, 1 top_count);
//   any such write clears the sequence state, other indexes are ignored
// - one item is worked on at a time; in_stall is high from acceptance until
//   the result is loaded into the output register (or the item is retired)
// - per item: the table is searched entry by entry (once for the value
//   leaving the window, once for the new one), the changed entry moves one
//   rank position at a time, and each summed entry is read, multiplied and
//   accumulated; the pace is set by the single read port of the
//   distinct-value table
// - the table stays in rank order, so the sum walks min(top_count, distinct)
//   entries from the top
// - a result waits in the output register while out_stall is high; the next
//   item is still taken, and only its own result waits for the slot
// - reset clears the counters and sets both registers to 1; the memories
//   hold no reset and are only read where written
// - an item marked last clears the window after its result is loaded
`include "sliding_window_top_x_frequency_sum_unit_defines.svh"
module sliding_window_top_x_frequency_sum_unit import swtx_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      value,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SUM_W-1:0] window_sum,
    output logic                    partial,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [REG_W-1:0]        cfg_data
);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int VB    = VALUE_BITS;
    localparam int TW    = VB + CW;
    localparam logic [CW:0] MAXV = (CW+1)'(WINDOW_MAX);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HWAIT = 4'd1;
    localparam logic [3:0] S_FRD   = 4'd2;
    localparam logic [3:0] S_FCMP  = 4'd3;
    localparam logic [3:0] S_DRD   = 4'd4;
    localparam logic [3:0] S_DCMP  = 4'd5;
    localparam logic [3:0] S_URD   = 4'd6;
    localparam logic [3:0] S_UCMP  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_SRD   = 4'd9;
    localparam logic [3:0] S_SMUL  = 4'd10;
    localparam logic [3:0] S_SACC  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // control state
    logic [3:0]       state_reg, state_next;
    logic             mode_reg, mode_next;
    logic [CW-1:0]    used_reg, used_next;
    logic [CW-1:0]    seen_reg, seen_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [REG_W-1:0] wlen_reg, wlen_next;
    logic [REG_W-1:0] top_reg, top_next;
    logic             out_valid_reg, out_valid_next;

    // working registers of the current item
    logic [VB-1:0]    value_reg, value_next;
    logic             last_reg, last_next;
    logic [VB-1:0]    target_reg, target_next;
    logic [VB-1:0]    cur_val_reg, cur_val_next;
    logic [CW-1:0]    cur_cnt_reg, cur_cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [CW-1:0]    n_reg, n_next;
    logic             part_reg, part_next;
    logic             part_out_reg, part_out_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    // memory ports
    logic             hist_we;
    logic [IDX_W-1:0] hist_waddr, hist_raddr;
    logic [VB-1:0]    hist_wdata, hist_rdata;
    logic             tab_we;
    logic [IDX_W-1:0] tab_waddr, tab_raddr;
    logic [TW-1:0]    tab_wdata, tab_rdata;
    logic [VB-1:0]    rd_val;
    logic [CW-1:0]    rd_cnt;

    mac_ctl_t                mac_ctl;
    logic signed [SUM_W-1:0] mac_acc;

    // helpers
    logic [CW-1:0]    w_eff;
    logic [CW:0]      old_sum, old_red;
    logic [IDX_W-1:0] old_addr;
    logic [IDX_W-1:0] ptr_inc;
    logic [CW-1:0]    seen_inc;
    logic [CW:0]      idx_p1;
    logic [CW-1:0]    idx_m1;
    logic [CW-1:0]    n_calc;
    logic             cur_clear;

    function automatic logic ranks_above(input logic [CW-1:0] ca, input logic [VB-1:0] va,
                                         input logic [CW-1:0] cb, input logic [VB-1:0] vb);
        logic res;
        if (ca != cb)
        begin
            res = ca > cb;
        end
        else
        begin
            res = $signed(va) > $signed(vb);
        end
        return res;
    endfunction

    assign rd_val = tab_rdata[TW-1:CW];
    assign rd_cnt = tab_rdata[CW-1:0];

    // window length held to 1..WINDOW_MAX
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(wlen_reg) > WINDOW_MAX)
        begin
            w_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            w_eff = CW'(wlen_reg);
        end
    end

    // ring slot of the item leaving the window
    assign old_sum  = (CW+1)'(ptr_reg) + (MAXV - {1'b0, w_eff});
    assign old_red  = (old_sum >= MAXV) ? (old_sum - MAXV) : old_sum;
    assign old_addr = old_red[IDX_W-1:0];
    assign ptr_inc  = (ptr_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : ptr_reg + 1'b1;
    assign seen_inc = (seen_reg < w_eff) ? seen_reg + 1'b1 : seen_reg;
    assign idx_p1   = {1'b0, idx_reg} + 1'b1;
    assign idx_m1   = idx_reg - 1'b1;
    assign n_calc   = (32'(top_reg) < 32'(used_reg)) ? CW'(top_reg) : used_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        used_next      = used_reg;
        seen_next      = seen_reg;
        ptr_next       = ptr_reg;
        wlen_next      = wlen_reg;
        top_next       = top_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        target_next    = target_reg;
        cur_val_next   = cur_val_reg;
        cur_cnt_next   = cur_cnt_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        part_next      = part_reg;
        part_out_next  = part_out_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        hist_we        = 1'b0;
        hist_waddr     = ptr_reg;
        hist_wdata     = value_reg;
        hist_raddr     = old_addr;
        tab_we         = 1'b0;
        tab_waddr      = idx_reg[IDX_W-1:0];
        tab_wdata      = {cur_val_reg, cur_cnt_reg};
        tab_raddr      = k_reg[IDX_W-1:0];
        mac_ctl        = '0;
        cur_clear      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = value[VB-1:0];
                    last_next  = last;
                    state_next = S_HWAIT;
                end
            end
            S_HWAIT:
            begin
                // old value is ready from the ring
                if (seen_reg >= w_eff)
                begin
                    target_next = hist_rdata;
                    mode_next   = MODE_REMOVE;
                end
                else
                begin
                    target_next = value_reg;
                    mode_next   = MODE_ADD;
                end
                k_next     = '0;
                state_next = S_FRD;
            end
            S_FRD:
            begin
                if (k_reg == used_reg)
                begin
                    if (mode_reg == MODE_REMOVE)
                    begin
                        target_next = value_reg;
                        mode_next   = MODE_ADD;
                        k_next      = '0;
                    end
                    else if (used_reg == CW'(WINDOW_MAX))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cur_val_next = value_reg;
                        cur_cnt_next = CW'(1);
                        idx_next     = used_reg;
                        used_next    = used_reg + 1'b1;
                        state_next   = S_URD;
                    end
                end
                else
                begin
                    tab_raddr  = k_reg[IDX_W-1:0];
                    state_next = S_FCMP;
                end
            end
            S_FCMP:
            begin
                if (rd_val == target_reg)
                begin
                    cur_val_next = rd_val;
                    idx_next     = k_reg;
                    if (mode_reg == MODE_REMOVE)
                    begin
                        cur_cnt_next = rd_cnt - 1'b1;
                        state_next   = S_DRD;
                    end
                    else
                    begin
                        cur_cnt_next = rd_cnt + 1'b1;
                        state_next   = S_URD;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_FRD;
                end
            end
            S_DRD:
            begin
                if (idx_p1 < {1'b0, used_reg})
                begin
                    tab_raddr  = idx_p1[IDX_W-1:0];
                    state_next = S_DCMP;
                end
                else
                begin
                    cur_clear = 1'b1;
                end
            end
            S_DCMP:
            begin
                if (ranks_above(rd_cnt, rd_val, cur_cnt_reg, cur_val_reg))
                begin
                    tab_we     = 1'b1;
                    tab_wdata  = tab_rdata;
                    idx_next   = idx_p1[CW-1:0];
                    state_next = S_DRD;
                end
                else
                begin
                    cur_clear = 1'b1;
                end
            end
            S_URD:
            begin
                if (idx_reg != '0)
                begin
                    tab_raddr  = idx_m1[IDX_W-1:0];
                    state_next = S_UCMP;
                end
                else
                begin
                    tab_we     = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_UCMP:
            begin
                tab_we = 1'b1;
                if (ranks_above(cur_cnt_reg, cur_val_reg, rd_cnt, rd_val))
                begin
                    tab_wdata  = tab_rdata;
                    idx_next   = idx_m1;
                    state_next = S_URD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                hist_we   = 1'b1;
                ptr_next  = ptr_inc;
                seen_next = seen_inc;
                if ((seen_inc >= w_eff) || last_reg)
                begin
                    part_next  = !(seen_inc >= w_eff);
                    n_next     = (top_reg == '0) ? '0 : n_calc;
                    k_next     = '0;
                    mac_ctl.clear = 1'b1;
                    state_next = S_SRD;
                end
                else
                begin
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        used_next = '0;
                        seen_next = '0;
                        ptr_next  = '0;
                    end
                end
            end
            S_SRD:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    tab_raddr  = k_reg[IDX_W-1:0];
                    state_next = S_SMUL;
                end
            end
            S_SMUL:
            begin
                mac_ctl.mul = 1'b1;
                state_next  = S_SACC;
            end
            S_SACC:
            begin
                mac_ctl.acc = 1'b1;
                k_next      = k_reg + 1'b1;
                state_next  = S_SRD;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    sum_next       = mac_acc;
                    part_out_next  = part_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (last_reg)
                    begin
                        used_next = '0;
                        seen_next = '0;
                        ptr_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of the downward move: settle the entry, drop it if its count is gone
        if (cur_clear)
        begin
            tab_we      = 1'b1;
            if (cur_cnt_reg == '0)
            begin
                used_next = used_reg - 1'b1;
            end
            target_next = value_reg;
            mode_next   = MODE_ADD;
            k_next      = '0;
            state_next  = S_FRD;
        end

        // the user must make register writes only while idle; the block does not enforce it
        if (cfg_we)
        begin
            if (cfg_index == REG_WINDOW_LEN)
            begin
                wlen_next = cfg_data;
                used_next = '0;
                seen_next = '0;
                ptr_next  = '0;
            end
            else if (cfg_index == REG_TOP_COUNT)
            begin
                top_next  = cfg_data;
                used_next = '0;
                seen_next = '0;
                ptr_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_ADD;
            used_reg      <= '0;
            seen_reg      <= '0;
            ptr_reg       <= '0;
            wlen_reg      <= REG_W'(1);
            top_reg       <= REG_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            used_reg      <= used_next;
            seen_reg      <= seen_next;
            ptr_reg       <= ptr_next;
            wlen_reg      <= wlen_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        last_reg     <= last_next;
        target_reg   <= target_next;
        cur_val_reg  <= cur_val_next;
        cur_cnt_reg  <= cur_cnt_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        part_reg     <= part_next;
        part_out_reg <= part_out_next;
        sum_reg      <= sum_next;
    end

    // ring of the values in the window
    swtx_ram #(
        .DEPTH (WINDOW_MAX),
        .AW    (IDX_W),
        .DW    (VB)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // distinct values with counts, kept in rank order
    swtx_ram #(
        .DEPTH (WINDOW_MAX),
        .AW    (IDX_W),
        .DW    (TW)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    swtx_mac #(
        .CW (CW),
        .VB (VB)
    ) u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .cnt (rd_cnt),
        .val (rd_val),
        .acc (mac_acc)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign window_sum = sum_reg;
    assign partial    = part_out_reg;

    // checks
    `SWTX_ASSERT(a_used_bound, clk, rst_n, used_reg <= CW'(WINDOW_MAX))
    `SWTX_ASSERT(a_used_le_seen, clk, rst_n, (state_reg != S_IDLE) || (used_reg <= seen_reg))
    `SWTX_ASSERT(a_seen_le_win, clk, rst_n, (state_reg != S_IDLE) || (seen_reg <= w_eff))
    `SWTX_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_reg == S_HWAIT)
endmodule
